@@ hw/rtl/depth_reprojection_zbuffer_macros.svh @@
// assertion macros for the depth reprojection z-buffer
`ifndef DEPTH_REPROJECTION_ZBUFFER_MACROS_SVH
`define DEPTH_REPROJECTION_ZBUFFER_MACROS_SVH
`ifndef SYNTH
`define DRZ_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("zbuffer check failed");
`define DRZ_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("zbuffer check failed");
`else
`define DRZ_ASSERT(lbl, cond)
`define DRZ_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ hw/rtl/drz_pkg.sv @@
package drz_pkg;

	localparam int ACTION_W = 2;
	localparam int COL_W = 10;
	localparam int ROW_W = 9;
	localparam int DEPTH_W = 16;
	localparam int Z_W = 40;
	localparam int CFG_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_COEF = 6;

	localparam int IMAGE_WIDTH_DEF = 640;
	localparam int IMAGE_HEIGHT_DEF = 480;
	localparam int FRACTION_BITS_DEF = 16;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PROJECT = 2'd0,
		ACT_READ = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_M00_M01 = 3'd0,
		REG_M02_T0 = 3'd1,
		REG_M10_M11 = 3'd2,
		REG_M12_T1 = 3'd3,
		REG_M20_M21 = 3'd4,
		REG_M22_T2 = 3'd5,
		REG_FILL_ENABLE = 3'd6
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_P_MUL,
		ST_P_LIN,
		ST_P_MULD,
		ST_P_OFS,
		ST_P_NUM,
		ST_P_CHK,
		ST_P_DIV,
		ST_P_ADDR,
		ST_P_RD,
		ST_P_WR,
		ST_R_ADDR,
		ST_R_RD,
		ST_R_CHK,
		ST_N_RD,
		ST_N_ACC,
		ST_A_DIV,
		ST_RESULT
	} state_t;

	// 8-neighborhood offsets, center left out
	function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
		logic signed [1:0] r;
		case (k)
			3'd0, 3'd3, 3'd5: r = -2'sd1;
			3'd1, 3'd6: r = 2'sd0;
			default: r = 2'sd1;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
		logic signed [1:0] r;
		case (k)
			3'd0, 3'd1, 3'd2: r = -2'sd1;
			3'd3, 3'd4: r = 2'sd0;
			default: r = 2'sd1;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/drz_in_if.sv @@
interface drz_in_if;
	logic valid;
	logic ready;
	logic [drz_pkg::ACTION_W-1:0] action;
	logic [drz_pkg::COL_W-1:0] column;
	logic [drz_pkg::ROW_W-1:0] row;
	logic [drz_pkg::DEPTH_W-1:0] depth_value;

	modport source(output valid, action, column, row, depth_value, input ready);
	modport sink(input valid, action, column, row, depth_value, output ready);
endinterface

@@ hw/rtl/drz_out_if.sv @@
interface drz_out_if;
	logic valid;
	logic ready;
	logic [drz_pkg::Z_W-1:0] aligned_depth;
	logic was_filled;

	modport source(output valid, aligned_depth, was_filled, input ready);
	modport sink(input valid, aligned_depth, was_filled, output ready);
endinterface

@@ hw/rtl/drz_ram.sv @@
module drz_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/depth_reprojection_zbuffer.sv @@
// Depth-to-color reprojection into a z-buffer held in one synchronous RAM of
// IMAGE_WIDTH*IMAGE_HEIGHT entries of 40 bits. One item is worked on at a time.
// A project action runs a chain of multiply and add stages, a restoring divider
// that resolves one target bit of column and row per cycle, and a RAM
// read-compare-write. A read that falls back to the neighbor average adds the
// eight neighbor reads and, when any neighbor is set, a bit-serial average
// divide. A clear action, and the sweep after reset, zero the RAM one entry per
// cycle, during which no item is taken; configuration writes are taken at any
// time. A finished read result sits in an output register while the next item
// is taken; aligned_depth is unsigned with 16 fraction bits.
`include "depth_reprojection_zbuffer_macros.svh"

module depth_reprojection_zbuffer #(
	parameter int IMAGE_WIDTH = drz_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = drz_pkg::IMAGE_HEIGHT_DEF,
	parameter int FRACTION_BITS = drz_pkg::FRACTION_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	drz_in_if.sink in_ch,
	drz_out_if.source out_ch,
	input logic cfg_we,
	input logic [drz_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [drz_pkg::CFG_W-1:0] cfg_data
);

	localparam int ZW = drz_pkg::Z_W;
	localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int MAXD = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
	localparam int QB = $clog2(MAXD);
	localparam int DCW = $clog2(QB);
	localparam int PW = 63;
	localparam int NW = 63;
	localparam int SW = ZW + 3;
	localparam int SR = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
	localparam int SRM = (SR > 0) ? SR - 1 : 0;
	localparam int SL = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
	localparam logic [ADDR_W-1:0] W_A = ADDR_W'(IMAGE_WIDTH);
	localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);
	localparam logic [PW-1:0] MAX40 = {{(PW-ZW){1'b0}}, {ZW{1'b1}}};
	localparam logic [PW-1:0] RND = (SR > 0) ? (PW'(1) << SRM) : '0;

	drz_pkg::state_t state_q, state_d;

	logic [drz_pkg::CFG_W-1:0] coef_q [drz_pkg::NUM_COEF];
	logic fill_q;
	logic [ADDR_W-1:0] clr_ptr_q;

	logic [drz_pkg::COL_W-1:0] u_q;
	logic [drz_pkg::ROW_W-1:0] v_q;
	logic [drz_pkg::DEPTH_W-1:0] d_q;

	logic signed [42:0] a_s1 [3];
	logic signed [42:0] b_s1 [3];
	logic signed [44:0] lin_s2 [3];
	logic signed [61:0] pm_s3 [3];
	logic signed [PW-1:0] p_s4 [3];

	logic [PW-1:0] z_q;
	logic [NW-1:0] remx_q, remy_q, den_q;
	logic xneg_q, yneg_q;
	logic [NW+QB-1:0] dsh_q;
	logic [QB-1:0] qx_q, qy_q;
	logic [DCW-1:0] dcnt_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ZW-1:0] zq_q;

	logic [2:0] k_q;
	logic nb_ok_q;
	logic [SW-1:0] sum_q, aq_q;
	logic [3:0] cnt_q, arem_q;
	logic [5:0] acnt_q;
	logic [ZW-1:0] res_val_q;
	logic res_fill_q;

	logic out_valid_q, out_fill_q;
	logic [ZW-1:0] out_val_q;

	logic in_fire, in_ready;
	logic ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [ZW-1:0] ram_wdata, ram_rdata;
	logic res_load;

	// input decode
	logic act_zero_depth, rd_outside;
	logic [PW-1:0] zr_c;
	logic [ZW-1:0] zq_c;
	logic px_in_c, py_in_c;
	logic signed [13:0] nx_c, ny_c;
	logic nb_in_c;
	logic [ADDR_W-1:0] naddr_c;
	logic nb_hit_c;
	logic [SW-1:0] nsum_c;
	logic [3:0] ncnt_c;
	logic [NW+QB-1:0] rx_ext, ry_ext;
	logic bx_c, by_c;
	logic [4:0] atmp_c;
	logic abit_c;

	assign in_ready = (state_q == drz_pkg::ST_IDLE);
	assign in_fire = in_ch.valid && in_ready;
	assign in_ch.ready = in_ready;

	assign act_zero_depth = (in_ch.depth_value == '0);
	assign rd_outside = (32'(in_ch.column) >= 32'(IMAGE_WIDTH)) ||
		(32'(in_ch.row) >= 32'(IMAGE_HEIGHT));

	// z rescaled to 16 fraction bits, saturated, never zero
	always_comb begin
		if (FRACTION_BITS >= 16)
			zr_c = (z_q + RND) >> SR;
		else
			zr_c = (z_q > (MAX40 >> SL)) ? MAX40 : (z_q << SL);
		zq_c = (zr_c > MAX40) ? {ZW{1'b1}} : zr_c[ZW-1:0];
		if (zq_c == '0)
			zq_c = ZW'(1);
	end

	assign px_in_c = (!xneg_q || qx_q == '0) && ({1'b0, qx_q} < (QB+1)'(IMAGE_WIDTH));
	assign py_in_c = (!yneg_q || qy_q == '0) && ({1'b0, qy_q} < (QB+1)'(IMAGE_HEIGHT));

	assign rx_ext = (NW+QB)'(remx_q);
	assign ry_ext = (NW+QB)'(remy_q);
	assign bx_c = (rx_ext >= dsh_q);
	assign by_c = (ry_ext >= dsh_q);

	// neighbor position
	assign nx_c = $signed({4'b0, u_q}) + 14'(drz_pkg::nb_dx(k_q));
	assign ny_c = $signed({5'b0, v_q}) + 14'(drz_pkg::nb_dy(k_q));
	assign nb_in_c = (nx_c >= 0) && (nx_c < $signed(14'(IMAGE_WIDTH))) &&
		(ny_c >= 0) && (ny_c < $signed(14'(IMAGE_HEIGHT)));
	assign naddr_c = ADDR_W'(ADDR_W'(ny_c) * W_A + ADDR_W'(nx_c));

	assign nb_hit_c = nb_ok_q && (ram_rdata != '0);
	assign nsum_c = nb_hit_c ? sum_q + SW'(ram_rdata) : sum_q;
	assign ncnt_c = nb_hit_c ? cnt_q + 4'd1 : cnt_q;

	assign atmp_c = {arem_q, aq_q[SW-1]};
	assign abit_c = (atmp_c >= 5'(cnt_q));

	// next state and RAM control
	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = zq_q;
		ram_re = 1'b0;
		ram_raddr = addr_q;
		res_load = 1'b0;
		case (state_q)
			drz_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_ptr_q;
				ram_wdata = '0;
				if (clr_ptr_q == LAST_A)
					state_d = drz_pkg::ST_IDLE;
			end
			drz_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (drz_pkg::action_t'(in_ch.action))
						drz_pkg::ACT_PROJECT:
							if (!act_zero_depth)
								state_d = drz_pkg::ST_P_MUL;
						drz_pkg::ACT_READ:
							state_d = rd_outside ? drz_pkg::ST_RESULT : drz_pkg::ST_R_ADDR;
						drz_pkg::ACT_CLEAR:
							state_d = drz_pkg::ST_CLEAR;
						default: state_d = drz_pkg::ST_IDLE;
					endcase
				end
			end
			drz_pkg::ST_P_MUL: state_d = drz_pkg::ST_P_LIN;
			drz_pkg::ST_P_LIN: state_d = drz_pkg::ST_P_MULD;
			drz_pkg::ST_P_MULD: state_d = drz_pkg::ST_P_OFS;
			drz_pkg::ST_P_OFS: state_d = drz_pkg::ST_P_NUM;
			drz_pkg::ST_P_NUM: begin
				if (p_s4[2][PW-1] || p_s4[2] == '0)
					state_d = drz_pkg::ST_IDLE;
				else
					state_d = drz_pkg::ST_P_CHK;
			end
			drz_pkg::ST_P_CHK: begin
				// quotient too large for any frame position
				if (rx_ext >= {den_q, {QB{1'b0}}} || ry_ext >= {den_q, {QB{1'b0}}})
					state_d = drz_pkg::ST_IDLE;
				else
					state_d = drz_pkg::ST_P_DIV;
			end
			drz_pkg::ST_P_DIV:
				if (dcnt_q == '0)
					state_d = drz_pkg::ST_P_ADDR;
			drz_pkg::ST_P_ADDR:
				state_d = (px_in_c && py_in_c) ? drz_pkg::ST_P_RD : drz_pkg::ST_IDLE;
			drz_pkg::ST_P_RD: begin
				ram_re = 1'b1;
				state_d = drz_pkg::ST_P_WR;
			end
			drz_pkg::ST_P_WR: begin
				// equal z keeps the stored entry
				ram_we = (ram_rdata == '0) || (zq_q < ram_rdata);
				state_d = drz_pkg::ST_IDLE;
			end
			drz_pkg::ST_R_ADDR: state_d = drz_pkg::ST_R_RD;
			drz_pkg::ST_R_RD: begin
				ram_re = 1'b1;
				state_d = drz_pkg::ST_R_CHK;
			end
			drz_pkg::ST_R_CHK:
				state_d = (ram_rdata != '0 || !fill_q) ? drz_pkg::ST_RESULT :
					drz_pkg::ST_N_RD;
			drz_pkg::ST_N_RD: begin
				ram_re = nb_in_c;
				ram_raddr = naddr_c;
				state_d = drz_pkg::ST_N_ACC;
			end
			drz_pkg::ST_N_ACC: begin
				if (k_q != 3'd7)
					state_d = drz_pkg::ST_N_RD;
				else
					state_d = (ncnt_c == '0) ? drz_pkg::ST_RESULT : drz_pkg::ST_A_DIV;
			end
			drz_pkg::ST_A_DIV:
				if (acnt_q == '0)
					state_d = drz_pkg::ST_RESULT;
			drz_pkg::ST_RESULT: begin
				if (!out_valid_q || out_ch.ready) begin
					res_load = 1'b1;
					state_d = drz_pkg::ST_IDLE;
				end
			end
			default: state_d = drz_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drz_pkg::ST_CLEAR;
			clr_ptr_q <= '0;
			out_valid_q <= 1'b0;
			fill_q <= 1'b0;
			for (int i = 0; i < drz_pkg::NUM_COEF; i++)
				coef_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == drz_pkg::ST_CLEAR)
				clr_ptr_q <= (clr_ptr_q == LAST_A) ? '0 : clr_ptr_q + ADDR_W'(1);
			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == drz_pkg::REG_FILL_ENABLE)
					fill_q <= cfg_data[0];
				else if (32'(cfg_index) < drz_pkg::NUM_COEF)
					coef_q[cfg_index] <= cfg_data;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_val_q <= res_val_q;
			out_fill_q <= res_fill_q;
		end
		case (state_q)
			drz_pkg::ST_IDLE: begin
				if (in_fire) begin
					u_q <= in_ch.column;
					v_q <= in_ch.row;
					d_q <= in_ch.depth_value;
					res_val_q <= '0;
					res_fill_q <= 1'b0;
				end
			end
			drz_pkg::ST_P_MUL: begin
				for (int r = 0; r < 3; r++) begin
					a_s1[r] <= $signed(coef_q[2*r][31:0]) * $signed({1'b0, u_q});
					b_s1[r] <= 43'($signed(coef_q[2*r][63:32]) * $signed({1'b0, v_q}));
				end
			end
			drz_pkg::ST_P_LIN: begin
				for (int r = 0; r < 3; r++)
					lin_s2[r] <= 45'(a_s1[r]) + 45'(b_s1[r]) +
						45'($signed(coef_q[2*r+1][31:0]));
			end
			drz_pkg::ST_P_MULD: begin
				for (int r = 0; r < 3; r++)
					pm_s3[r] <= lin_s2[r] * $signed({1'b0, d_q});
			end
			drz_pkg::ST_P_OFS: begin
				for (int r = 0; r < 3; r++)
					p_s4[r] <= PW'(pm_s3[r]) + PW'($signed(coef_q[2*r+1][63:32]));
			end
			drz_pkg::ST_P_NUM: begin
				// numerator 2|p|+z over 2z gives the half-away rounding
				z_q <= p_s4[2];
				den_q <= NW'(p_s4[2]) << 1;
				xneg_q <= p_s4[0][PW-1];
				yneg_q <= p_s4[1][PW-1];
				remx_q <= ((p_s4[0][PW-1] ? NW'(-p_s4[0]) : NW'(p_s4[0])) << 1) +
					NW'(p_s4[2]);
				remy_q <= ((p_s4[1][PW-1] ? NW'(-p_s4[1]) : NW'(p_s4[1])) << 1) +
					NW'(p_s4[2]);
			end
			drz_pkg::ST_P_CHK: begin
				dsh_q <= (NW+QB)'(den_q) << (QB - 1);
				dcnt_q <= DCW'(QB - 1);
			end
			drz_pkg::ST_P_DIV: begin
				if (bx_c)
					remx_q <= NW'(rx_ext - dsh_q);
				if (by_c)
					remy_q <= NW'(ry_ext - dsh_q);
				qx_q <= {qx_q[QB-2:0], bx_c};
				qy_q <= {qy_q[QB-2:0], by_c};
				dsh_q <= dsh_q >> 1;
				dcnt_q <= dcnt_q - DCW'(1);
			end
			drz_pkg::ST_P_ADDR: begin
				addr_q <= ADDR_W'(ADDR_W'(qy_q) * W_A + ADDR_W'(qx_q));
				zq_q <= zq_c;
			end
			drz_pkg::ST_R_ADDR:
				addr_q <= ADDR_W'(ADDR_W'(v_q) * W_A + ADDR_W'(u_q));
			drz_pkg::ST_R_CHK: begin
				res_val_q <= ram_rdata;
				sum_q <= '0;
				cnt_q <= '0;
				k_q <= '0;
			end
			drz_pkg::ST_N_RD:
				nb_ok_q <= nb_in_c;
			drz_pkg::ST_N_ACC: begin
				sum_q <= nsum_c;
				cnt_q <= ncnt_c;
				k_q <= k_q + 3'd1;
				// rounding half up: add half the count before dividing
				aq_q <= nsum_c + SW'(ncnt_c >> 1);
				arem_q <= '0;
				acnt_q <= 6'(SW - 1);
			end
			drz_pkg::ST_A_DIV: begin
				arem_q <= abit_c ? 4'(atmp_c - 5'(cnt_q)) : atmp_c[3:0];
				aq_q <= {aq_q[SW-2:0], abit_c};
				acnt_q <= acnt_q - 6'd1;
				if (acnt_q == '0) begin
					res_val_q <= ZW'({aq_q[SW-2:0], abit_c});
					res_fill_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	drz_ram #(
		.WIDTH(ZW),
		.DEPTH(DEPTH)
	) u_zbuf (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_ch.valid = out_valid_q;
	assign out_ch.aligned_depth = out_val_q;
	assign out_ch.was_filled = out_fill_q;

	`DRZ_ASSERT(a_write_src, !ram_we || state_q == drz_pkg::ST_CLEAR || state_q == drz_pkg::ST_P_WR)
	`DRZ_ASSERT(a_proj_nonzero, !(ram_we && state_q == drz_pkg::ST_P_WR) || ram_wdata != '0)
	`DRZ_ASSERT_NEXT(a_sweep_end, state_q == drz_pkg::ST_CLEAR && clr_ptr_q == LAST_A, state_q == drz_pkg::ST_IDLE && clr_ptr_q == '0)
	`DRZ_ASSERT(a_fill_nonzero, !(out_valid_q && out_fill_q) || out_val_q != '0)

endmodule

@@ tb/drz_tb_pkg.sv @@
package drz_tb_pkg;

	// action code outside the package enum, taken by the block and dropped
	localparam logic [1:0] ACT_IGNORED = 2'd3;

	localparam logic [39:0] Z_MAX = 40'hFF_FFFF_FFFF;
	localparam int unsigned ONE_Q = 32'h0001_0000;

	typedef struct {
		logic [39:0] z;
		logic filled;
	} depth_result_t;

	typedef struct {
		logic [1:0] act;
		int unsigned col;
		int unsigned row;
		int unsigned depth;
		bit known;
		logic [39:0] known_z;
		logic known_filled;
	} stim_row_t;

endpackage

@@ tb/drz_test_ifs.sv @@
// channel interfaces come from the rtl folder so the bench and the block share one definition

@@ tb/depth_reprojection_zbuffer_test.sv @@
module depth_reprojection_zbuffer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import drz_pkg::*;
	import drz_tb_pkg::*;

	localparam int W = 640;
	localparam int H = 480;
	// a clear sweep alone passes without a transfer
	localparam int STALL_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	drz_in_if in_if();
	drz_out_if out_if();

	depth_reprojection_zbuffer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_if),
		.out_ch(out_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [39:0] zbuf[int];
	logic [63:0] coef[NUM_COEF];
	logic fill_on;

	depth_result_t pending[$];
	int errors = 0;
	bit idle_on = 1'b1;
	int out_stall = 0;
	int quiet_cycles = 0;

	function automatic longint coef_half(logic [63:0] w, bit hi);
		int h;
		h = hi ? w[63:32] : w[31:0];
		return longint'(h);
	endfunction

	function automatic longint project_row(int r, longint u, longint v, longint d);
		longint lin;
		lin = coef_half(coef[2*r], 0) * u + coef_half(coef[2*r], 1) * v
			+ coef_half(coef[2*r+1], 0);
		return lin * d + coef_half(coef[2*r+1], 1);
	endfunction

	function automatic longint round_half_away(longint x, longint z);
		longint unsigned mag, q;
		mag = (x < 0) ? longint'(-x) : x;
		q = (2 * mag + longint'(z)) / (2 * longint'(z));
		return (x < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [39:0] stored_z(int idx);
		return zbuf.exists(idx) ? zbuf[idx] : 40'd0;
	endfunction

	// updates the z-buffer copy; returns 1 when the item produces a result
	function automatic bit predict_item(logic [1:0] act, longint u, longint v, longint d,
			output depth_result_t res);
		longint x, y, z, qx, qy;
		logic [39:0] zq, cur;
		logic [63:0] sum;
		int cnt, idx;
		res.z = '0;
		res.filled = 1'b0;
		case (act)
			ACT_PROJECT: begin
				if (d == 0) return 0;
				z = project_row(2, u, v, d);
				if (z <= 0) return 0;
				x = project_row(0, u, v, d);
				y = project_row(1, u, v, d);
				qx = round_half_away(x, z);
				qy = round_half_away(y, z);
				if (qx < 0 || qx >= W || qy < 0 || qy >= H) return 0;
				zq = (z > longint'(Z_MAX)) ? Z_MAX : z[39:0];
				if (zq == 0) zq = 40'd1;
				idx = int'(qy) * W + int'(qx);
				cur = stored_z(idx);
				if (cur == 0 || zq < cur) zbuf[idx] = zq;
				return 0;
			end
			ACT_READ: begin
				if (u >= W || v >= H) return 1;
				res.z = stored_z(int'(v) * W + int'(u));
				if (res.z != 0 || !fill_on) return 1;
				sum = '0;
				cnt = 0;
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++) begin
						if (dx == 0 && dy == 0) continue;
						if (u + dx < 0 || u + dx >= W || v + dy < 0 || v + dy >= H) continue;
						cur = stored_z(int'(v + dy) * W + int'(u + dx));
						if (cur != 0) begin
							sum += cur;
							cnt++;
						end
					end
				if (cnt == 0) return 1;
				res.z = 40'((sum + cnt / 2) / cnt);
				res.filled = 1'b1;
				return 1;
			end
			ACT_CLEAR: begin
				zbuf.delete();
				return 0;
			end
			default: return 0;
		endcase
	endfunction

	task automatic wait_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_item(logic [1:0] act, int unsigned u, int unsigned v, int unsigned d,
			bit known, logic [39:0] kz, logic kf);
		int gap;
		depth_result_t res;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			wait_cycles(gap);
		end
		in_if.valid <= 1'b1;
		in_if.action <= act;
		in_if.column <= u[9:0];
		in_if.row <= v[8:0];
		in_if.depth_value <= d[15:0];
		do @(posedge clk); while (!in_if.ready);
		if (predict_item(act, u, v, d, res)) begin
			if (known) begin
				res.z = kz;
				res.filled = kf;
			end
			pending.push_back(res);
		end
	endtask

	// block must be idle before the registers change
	task automatic wait_idle();
		in_if.valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		wait_cycles(DRAIN_CYCLES);
	endtask

	task automatic load_registers(logic [63:0] regs[NUM_COEF], logic fill);
		for (int i = 0; i <= NUM_COEF; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= (i == NUM_COEF) ? REG_FILL_ENABLE : cfg_reg_t'(i);
			cfg_data <= (i == NUM_COEF) ? {$urandom, $urandom_range(0, 1) ? 32'hFFFF_FFFE : 32'h0}
				| 64'(fill) : regs[i];
			@(posedge clk);
			if (i < NUM_COEF) coef[i] = regs[i];
		end
		fill_on = fill;
		cfg_we <= 1'b0;
	endtask

	function automatic int small_signed(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic pick_registers(int phase, output logic [63:0] regs[NUM_COEF]);
		int m00, m01, m02, t0, m10, m11, m12, t1, m20, m21, m22, t2;
		m00 = ONE_Q + small_signed(1500);
		m01 = small_signed(400);
		m02 = small_signed(12) * int'(ONE_Q);
		t0 = small_signed(1 << 20);
		m10 = small_signed(400);
		m11 = ONE_Q + small_signed(1500);
		m12 = small_signed(12) * int'(ONE_Q);
		t1 = small_signed(1 << 20);
		m20 = (phase == 1) ? small_signed(4) : 0;
		m21 = (phase == 1) ? small_signed(4) : 0;
		m22 = ONE_Q + small_signed(800);
		t2 = small_signed(1 << 20);
		regs[0] = {32'(m01), 32'(m00)};
		regs[1] = {32'(t0), 32'(m02)};
		regs[2] = {32'(m11), 32'(m10)};
		regs[3] = {32'(t1), 32'(m12)};
		regs[4] = {32'(m21), 32'(m20)};
		regs[5] = {32'(t2), 32'(m22)};
		for (int i = 0; i < NUM_COEF; i++)
			case (phase)
				2: regs[i] = {$urandom, $urandom};
				3: regs[i] = '1;
				4: regs[i] = $urandom_range(0, 1) ? 64'h7FFF_FFFF_8000_0000
					: 64'h8000_0000_7FFF_FFFF;
				default: ;
			endcase
	endtask

	stim_row_t directed[$] = '{
		'{ACT_READ, 0, 0, 0, 1, 40'd0, 1'b0},
		'{ACT_READ, 639, 479, 0, 1, 40'd0, 1'b0},
		'{ACT_PROJECT, 5, 7, 100, 0, 40'd0, 1'b0},
		'{ACT_READ, 5, 7, 0, 1, 40'd100 << 16, 1'b0},
		'{ACT_READ, 6, 8, 0, 1, 40'd100 << 16, 1'b1},
		'{ACT_PROJECT, 5, 7, 50, 0, 40'd0, 1'b0},
		'{ACT_PROJECT, 5, 7, 50, 0, 40'd0, 1'b0},
		'{ACT_PROJECT, 5, 7, 200, 0, 40'd0, 1'b0},
		'{ACT_READ, 5, 7, 0, 1, 40'd50 << 16, 1'b0},
		'{ACT_PROJECT, 0, 0, 65535, 0, 40'd0, 1'b0},
		'{ACT_PROJECT, 639, 479, 1, 0, 40'd0, 1'b0},
		'{ACT_READ, 0, 0, 0, 1, 40'd65535 << 16, 1'b0},
		'{ACT_READ, 639, 479, 0, 1, 40'd1 << 16, 1'b0},
		'{ACT_READ, 638, 478, 0, 1, 40'd1 << 16, 1'b1},
		'{ACT_PROJECT, 6, 7, 0, 0, 40'd0, 1'b0},
		'{ACT_READ, 6, 7, 0, 1, 40'd50 << 16, 1'b1},
		'{ACT_PROJECT, 1023, 511, 10, 0, 40'd0, 1'b0},
		'{ACT_READ, 1023, 511, 65535, 1, 40'd0, 1'b0},
		'{ACT_READ, 640, 0, 0, 1, 40'd0, 1'b0},
		'{ACT_IGNORED, 1023, 511, 65535, 0, 40'd0, 1'b0},
		'{ACT_READ, 100, 100, 0, 1, 40'd0, 1'b0},
		'{ACT_CLEAR, 0, 0, 0, 0, 40'd0, 1'b0},
		'{ACT_READ, 5, 7, 0, 1, 40'd0, 1'b0}
	};

	// result side: stalls and checking
	always @(posedge clk) begin
		depth_result_t want;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				if (pending.size() == 0) begin
					$display("%0t unexpected result: expected none, actual z=%h filled=%b",
						$time, out_if.aligned_depth, out_if.was_filled);
					errors++;
				end else begin
					want = pending.pop_front();
					if (out_if.aligned_depth !== want.z) begin
						$display("%0t aligned_depth mismatch: expected %h, actual %h",
							$time, want.z, out_if.aligned_depth);
						errors++;
					end
					if (out_if.was_filled !== want.filled) begin
						$display("%0t was_filled mismatch: expected %b, actual %b",
							$time, want.filled, out_if.was_filled);
						errors++;
					end
				end
				out_stall = idle_on ? $urandom_range(0, 3) : 0;
			end
			if (out_stall > 0) begin
				out_if.ready <= 1'b0;
				out_stall--;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [63:0] regs[NUM_COEF];
		int unsigned u0, v0, u, v, d, pick;
		logic [1:0] act;
		in_if.valid = 1'b0;
		in_if.action = ACT_PROJECT;
		in_if.column = '0;
		in_if.row = '0;
		in_if.depth_value = '0;
		for (int i = 0; i < NUM_COEF; i++) coef[i] = '0;
		fill_on = 1'b0;
		wait_cycles(12);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit transform: target pixel equals the sample position, z = depth
		regs = '{64'(ONE_Q), 64'd0, {32'(ONE_Q), 32'd0}, 64'd0, 64'd0, 64'(ONE_Q)};
		load_registers(regs, 1'b1);
		foreach (directed[i])
			send_item(directed[i].act, directed[i].col, directed[i].row, directed[i].depth,
				directed[i].known, directed[i].known_z, directed[i].known_filled);

		for (int phase = 0; phase < 6; phase++) begin
			wait_idle();
			pick_registers(phase == 5 ? 0 : phase, regs);
			load_registers(regs, phase != 1 ? 1'b1 : ($urandom_range(0, 1) == 1));
			idle_on = (phase != 5);
			u0 = $urandom_range(0, W - 8);
			v0 = $urandom_range(0, H - 8);
			for (int n = 0; n < 225; n++) begin
				if ($urandom_range(0, 40) == 0) begin
					u0 = $urandom_range(0, 1) ? W - 8 : 0;
					v0 = $urandom_range(0, 1) ? H - 8 : $urandom_range(0, H - 8);
				end else if ($urandom_range(0, 30) == 0) begin
					u0 = $urandom_range(0, W - 8);
					v0 = $urandom_range(0, H - 8);
				end
				pick = $urandom_range(0, 99);
				act = (pick < 60) ? ACT_PROJECT : (pick < 98) ? ACT_READ : ACT_IGNORED;
				if ($urandom_range(0, 19) == 0) begin
					u = $urandom_range(0, 1023);
					v = $urandom_range(0, 511);
				end else begin
					u = u0 + $urandom_range(0, 7);
					v = v0 + $urandom_range(0, 7);
				end
				d = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 65535);
				send_item(act, u, v, d, 1'b0, 40'd0, 1'b0);
			end
		end

		in_if.valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		wait_cycles(DRAIN_CYCLES);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
